>>> rtl/gtr_pkg.sv
// Shared types, constants and the font table of the glyph text rasterizer.
package gtr_pkg;

    // Input transaction: a character or the start of a string.
    typedef struct packed {
        logic               op;
        logic [7:0]         char_code;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } gtr_in_t;

    // Output transaction: one pixel write.
    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } gtr_out_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_ADVANCE,
        ST_WRAP
    } gtr_state_t;

    // Operation codes.
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INK       = 3'd6;

    // Character codes.
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] FONT_FIRST = 8'd32;
    localparam logic [7:0] FONT_LAST  = 8'd127;

    // Display and glyph geometry.
    localparam logic [7:0] DISPLAY_HEIGHT = 8'd240;
    localparam int GLYPH_HEIGHT = 8;
    localparam logic [2:0] ROW_LAST = 3'(GLYPH_HEIGHT - 1);
    localparam logic [15:0] LINE_STEP = 16'(GLYPH_HEIGHT);

    // Font: one word per code, column 0 in the low byte, bit 0 is the top row.
    localparam int FONT_STRIDE = 6;
    localparam int FONT_CODES  = 96;
    localparam int GLYPH_BITS  = FONT_STRIDE * 8;
    localparam int FONT_ADDR_W = $clog2(FONT_CODES);

    localparam logic [GLYPH_BITS-1:0] FONT_GLYPHS [FONT_CODES] = '{
        48'h000000000000, 48'h00000000005F, 48'h000000070007, 48'h00147F147F14,
        48'h00122A7F2A24, 48'h006264081323, 48'h005022554936, 48'h000000000305,
        48'h00000041221C, 48'h0000001C2241, 48'h00082A1C2A08, 48'h0008083E0808,
        48'h000000003050, 48'h000000080808, 48'h000000003030, 48'h000204081020,
        48'h003E4549513E, 48'h000000407F42, 48'h004649516142, 48'h00314B454121,
        48'h00107F121418, 48'h003945454527, 48'h003049494A3C, 48'h000305097101,
        48'h003649494936, 48'h001E29494906, 48'h000000000036, 48'h000000003656,
        48'h000041221408, 48'h000000141414, 48'h000008142241, 48'h000609510102,
        48'h003E41794932, 48'h00007E11117E, 48'h00003649497F, 48'h00002241413E,
        48'h00001C22417F, 48'h00004149497F, 48'h00000109097F, 48'h00003251413E,
        48'h00007F08087F, 48'h000000417F41, 48'h00013F414020, 48'h00412214087F,
        48'h00000040407F, 48'h007F0204027F, 48'h007F1008047F, 48'h00003E41413E,
        48'h00000609097F, 48'h005E2151413E, 48'h00004629197F, 48'h000031494946,
        48'h000000017F01, 48'h00003F40403F, 48'h001F2040201F, 48'h007F2018207F,
        48'h006314081463, 48'h000304780403, 48'h004345495161, 48'h00000041417F,
        48'h002010080402, 48'h0000007F4141, 48'h000402010204, 48'h000000404040,
        48'h000000040201, 48'h000078545420, 48'h00003844487F, 48'h000000444438,
        48'h00007F484438, 48'h000018545438, 48'h000001097E08, 48'h00003C541408,
        48'h00007804087F, 48'h000000407D44, 48'h00003D444020, 48'h00004428107F,
        48'h000000407F41, 48'h00780418047C, 48'h00007804087C, 48'h000038444438,
        48'h00000814147C, 48'h00007C181408, 48'h00000804087C, 48'h000020545448,
        48'h000040443F04, 48'h00007C20403C, 48'h001C2040201C, 48'h003C4030403C,
        48'h004428102844, 48'h00003C50500C, 48'h00444C546444, 48'h000000413608,
        48'h00000000007F, 48'h000000083641, 48'h0000081C2A08, 48'h0000082A1C08
    };

    function automatic logic [GLYPH_BITS-1:0] gtr_font_glyph(
        input logic [FONT_ADDR_W-1:0] idx
    );
        logic [GLYPH_BITS-1:0] glyph;
        glyph = '0;
        if (int'(idx) < FONT_CODES) begin
            glyph = FONT_GLYPHS[idx];
        end
        return glyph;
    endfunction

endpackage

>>> rtl/glyph_text_rasterizer_core.sv
// Text rasterizer: renders characters from a 6x8 font RAM into clipped pixel writes.
// Start, carriage return and line feed transactions update the cursor directly;
// other non-printable codes only pass through the wrap check. A printable
// character is scanned one glyph bit per cycle while the pixel output is not
// stalled, ending early in compact mode, then flushed, advanced and wrap-checked.
// The font RAM loads from the built-in table after reset, taking no character then.
module glyph_text_rasterizer_core #(
    parameter int GLYPH_WIDTH = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gtr_pkg::gtr_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gtr_pkg::gtr_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [gtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]      cfg_data
);
    import gtr_pkg::*;

    localparam int COL_W = $clog2(GLYPH_WIDTH);
    localparam int ADV_W = $clog2(GLYPH_WIDTH + 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_WIDTH - 1);
    localparam logic [ADV_W-1:0] ADV_FULL = ADV_W'(GLYPH_WIDTH);

    gtr_state_t state_reg, state_next;
    logic [FONT_ADDR_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] margin_x_reg, margin_x_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [2:0] row_reg, row_next;
    logic [ADV_W-1:0] adv_reg, adv_next;
    logic pend_valid_reg, pend_valid_next;
    gtr_out_t pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    gtr_out_t m_data_reg, m_data_next;

    logic [7:0] win_x_min_reg, win_x_max_reg, win_y_min_reg, win_y_max_reg;
    logic terminal_reg, wrap_en_reg;
    logic [15:0] ink_reg;

    // Font RAM signals.
    logic ram_wr_en, ram_rd_en;
    logic [FONT_ADDR_W-1:0] ram_rd_addr;
    logic [GLYPH_BITS-1:0] ram_rd_data;

    logic s_fire, out_free;
    logic [63:0] glyph_cols;
    logic [7:0] col_bits;
    logic [15:0] px, py;
    logic x_ok, y_ok, hit, stop_early;
    gtr_out_t pixel;
    logic signed [16:0] wrap_sum;
    logic wrap_hit;

    gtr_ram #(
        .WIDTH(GLYPH_BITS),
        .DEPTH(FONT_CODES)
    ) u_font_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(fill_cnt_reg),
        .wr_data(gtr_font_glyph(fill_cnt_reg)),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign ram_wr_en   = (state_reg == ST_FILL);
    assign ram_rd_en   = s_fire;
    assign ram_rd_addr = FONT_ADDR_W'(s_data.char_code - FONT_FIRST);

    // Columns past the stored six read as blank.
    assign glyph_cols = {{(64 - GLYPH_BITS){1'b0}}, ram_rd_data};
    assign col_bits   = glyph_cols[{3'(col_reg), 3'b000} +: 8];

    assign px = cursor_x_reg + 16'(col_reg);
    assign py = cursor_y_reg + 16'(row_reg);

    // A coordinate at or above 256 is also negative or off the window.
    assign x_ok = (px[15:8] == 8'd0) && (px[7:0] >= win_x_min_reg)
               && (px[7:0] < win_x_max_reg);
    assign y_ok = (py[15:8] == 8'd0) && (py[7:0] < DISPLAY_HEIGHT)
               && (py[7:0] >= win_y_min_reg) && (py[7:0] < win_y_max_reg);
    assign hit  = col_bits[row_reg] && x_ok && y_ok;

    // In compact mode a blank column after the first ends the glyph.
    assign stop_early = !terminal_reg && (col_reg != '0) && (col_bits == 8'd0);

    always_comb begin
        pixel.pixel_x     = px[7:0];
        pixel.pixel_y     = py[7:0];
        pixel.pixel_color = ink_reg;
        pixel.last_pixel  = 1'b0;
    end

    assign wrap_sum = $signed({cursor_x_reg[15], cursor_x_reg}) + 17'(GLYPH_WIDTH);
    assign wrap_hit = wrap_en_reg && (wrap_sum > $signed({9'd0, win_x_max_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            fill_cnt_reg   <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            margin_x_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_cnt_reg   <= fill_cnt_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            margin_x_reg   <= margin_x_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        adv_reg    <= adv_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_x_min_reg <= 8'd0;
            win_x_max_reg <= 8'd240;
            win_y_min_reg <= 8'd0;
            win_y_max_reg <= 8'd240;
            terminal_reg  <= 1'b0;
            wrap_en_reg   <= 1'b0;
            ink_reg       <= 16'hFFFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WIN_X_MIN: win_x_min_reg <= cfg_data[7:0];
                CFG_WIN_X_MAX: win_x_max_reg <= cfg_data[7:0];
                CFG_WIN_Y_MIN: win_y_min_reg <= cfg_data[7:0];
                CFG_WIN_Y_MAX: win_y_max_reg <= cfg_data[7:0];
                CFG_TERMINAL:  terminal_reg  <= cfg_data[0];
                CFG_WRAP:      wrap_en_reg   <= cfg_data[0];
                CFG_INK:       ink_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic     push;
        gtr_out_t push_data;

        state_next      = state_reg;
        fill_cnt_next   = fill_cnt_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        margin_x_next   = margin_x_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        adv_next        = adv_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_data       = pend_reg;

        case (state_reg)
            ST_FILL: begin
                fill_cnt_next = fill_cnt_reg + FONT_ADDR_W'(1);
                if (fill_cnt_reg == FONT_ADDR_W'(FONT_CODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.op == OP_START) begin
                        cursor_x_next = s_data.start_x;
                        margin_x_next = s_data.start_x;
                        cursor_y_next = s_data.start_y;
                    end else if (s_data.char_code == CHAR_CR) begin
                        cursor_x_next = margin_x_reg;
                    end else if (s_data.char_code == CHAR_LF) begin
                        cursor_y_next = cursor_y_reg + LINE_STEP;
                    end else if (s_data.char_code inside {[FONT_FIRST:FONT_LAST]}) begin
                        col_next   = '0;
                        row_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_SCAN: begin
                if (stop_early) begin
                    adv_next   = ADV_W'(col_reg) + ADV_W'(1);
                    state_next = ST_FLUSH;
                end else if (!(hit && pend_valid_reg && !out_free)) begin
                    // The newest pixel waits in the pending slot until the next
                    // one shows whether it ends the character.
                    if (hit) begin
                        push            = pend_valid_reg;
                        pend_next       = pixel;
                        pend_valid_next = 1'b1;
                    end
                    if (row_reg == ROW_LAST) begin
                        row_next = '0;
                        if (col_reg == COL_LAST) begin
                            adv_next   = ADV_FULL;
                            state_next = ST_FLUSH;
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end else begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_ADVANCE;
                end else if (out_free) begin
                    push                 = 1'b1;
                    push_data.last_pixel = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cursor_x_next = cursor_x_reg + 16'(adv_reg);
                state_next    = ST_WRAP;
            end
            ST_WRAP: begin
                if (wrap_hit) begin
                    cursor_y_next = cursor_y_reg + LINE_STEP;
                    cursor_x_next = margin_x_reg;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_data;
        end
    end

endmodule

>>> rtl/gtr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sim/pixel_check_pkg.sv
// Font table and pixel scoreboard used by the glyph text rasterizer testbench.
package pixel_check_pkg;

    import gtr_pkg::*;

    localparam int GLYPH_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Six column bytes per code from 32 to 127; bit 0 of a column is the top row.
    localparam logic [7:0] GLYPH_COLUMNS [576] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h07, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14, 8'h00,
        8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h00, 8'h23, 8'h13, 8'h08, 8'h64, 8'h62, 8'h00,
        8'h36, 8'h49, 8'h55, 8'h22, 8'h50, 8'h00, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h1C, 8'h22, 8'h41, 8'h00, 8'h00, 8'h00, 8'h41, 8'h22, 8'h1C, 8'h00, 8'h00, 8'h00,
        8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08, 8'h00, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08, 8'h00,
        8'h50, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00,
        8'h30, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h00,
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00, 8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00,
        8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h56, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h08, 8'h14, 8'h22, 8'h41, 8'h00, 8'h00, 8'h14, 8'h14, 8'h14, 8'h00, 8'h00, 8'h00,
        8'h41, 8'h22, 8'h14, 8'h08, 8'h00, 8'h00, 8'h02, 8'h01, 8'h51, 8'h09, 8'h06, 8'h00,
        8'h32, 8'h49, 8'h79, 8'h41, 8'h3E, 8'h00, 8'h7E, 8'h11, 8'h11, 8'h7E, 8'h00, 8'h00,
        8'h7F, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00, 8'h3E, 8'h41, 8'h41, 8'h22, 8'h00, 8'h00,
        8'h7F, 8'h41, 8'h22, 8'h1C, 8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h41, 8'h00, 8'h00,
        8'h7F, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00, 8'h3E, 8'h41, 8'h51, 8'h32, 8'h00, 8'h00,
        8'h7F, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h00,
        8'h20, 8'h40, 8'h41, 8'h3F, 8'h01, 8'h00, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00,
        8'h7F, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F, 8'h00,
        8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h3E, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00,
        8'h7F, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00, 8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 8'h00,
        8'h7F, 8'h19, 8'h29, 8'h46, 8'h00, 8'h00, 8'h46, 8'h49, 8'h49, 8'h31, 8'h00, 8'h00,
        8'h01, 8'h7F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h3F, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h00,
        8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h00, 8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F, 8'h00,
        8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h00, 8'h03, 8'h04, 8'h78, 8'h04, 8'h03, 8'h00,
        8'h61, 8'h51, 8'h49, 8'h45, 8'h43, 8'h00, 8'h7F, 8'h41, 8'h41, 8'h00, 8'h00, 8'h00,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h00, 8'h41, 8'h41, 8'h7F, 8'h00, 8'h00, 8'h00,
        8'h04, 8'h02, 8'h01, 8'h02, 8'h04, 8'h00, 8'h40, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h01, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h20, 8'h54, 8'h54, 8'h78, 8'h00, 8'h00,
        8'h7F, 8'h48, 8'h44, 8'h38, 8'h00, 8'h00, 8'h38, 8'h44, 8'h44, 8'h00, 8'h00, 8'h00,
        8'h38, 8'h44, 8'h48, 8'h7F, 8'h00, 8'h00, 8'h38, 8'h54, 8'h54, 8'h18, 8'h00, 8'h00,
        8'h08, 8'h7E, 8'h09, 8'h01, 8'h00, 8'h00, 8'h08, 8'h14, 8'h54, 8'h3C, 8'h00, 8'h00,
        8'h7F, 8'h08, 8'h04, 8'h78, 8'h00, 8'h00, 8'h44, 8'h7D, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h20, 8'h40, 8'h44, 8'h3D, 8'h00, 8'h00, 8'h7F, 8'h10, 8'h28, 8'h44, 8'h00, 8'h00,
        8'h41, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h04, 8'h18, 8'h04, 8'h78, 8'h00,
        8'h7C, 8'h08, 8'h04, 8'h78, 8'h00, 8'h00, 8'h38, 8'h44, 8'h44, 8'h38, 8'h00, 8'h00,
        8'h7C, 8'h14, 8'h14, 8'h08, 8'h00, 8'h00, 8'h08, 8'h14, 8'h18, 8'h7C, 8'h00, 8'h00,
        8'h7C, 8'h08, 8'h04, 8'h08, 8'h00, 8'h00, 8'h48, 8'h54, 8'h54, 8'h20, 8'h00, 8'h00,
        8'h04, 8'h3F, 8'h44, 8'h40, 8'h00, 8'h00, 8'h3C, 8'h40, 8'h20, 8'h7C, 8'h00, 8'h00,
        8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C, 8'h00, 8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C, 8'h00,
        8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 8'h00, 8'h0C, 8'h50, 8'h50, 8'h3C, 8'h00, 8'h00,
        8'h44, 8'h64, 8'h54, 8'h4C, 8'h44, 8'h00, 8'h08, 8'h36, 8'h41, 8'h00, 8'h00, 8'h00,
        8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h36, 8'h08, 8'h00, 8'h00, 8'h00,
        8'h08, 8'h2A, 8'h1C, 8'h08, 8'h00, 8'h00, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h00, 8'h00
    };

    function automatic logic [7:0] glyph_column(logic [7:0] code, int col);
        if (col >= FONT_STRIDE || code < FONT_FIRST || code > FONT_LAST) begin
            return 8'h00;
        end
        return GLYPH_COLUMNS[(int'(code) - int'(FONT_FIRST)) * FONT_STRIDE + col];
    endfunction

    class pixel_scoreboard;
        logic [15:0] cursor_col;
        logic [15:0] cursor_row;
        logic [15:0] margin_col;
        int          win_x_min;
        int          win_x_max;
        int          win_y_min;
        int          win_y_max;
        bit          fixed_advance;
        bit          wrap_on;
        logic [15:0] ink;
        gtr_out_t    expected_pixels[$];
        int          mismatches;

        function new();
            cursor_col    = '0;
            cursor_row    = '0;
            margin_col    = '0;
            win_x_min     = 0;
            win_x_max     = 240;
            win_y_min     = 0;
            win_y_max     = 240;
            fixed_advance = 1'b0;
            wrap_on       = 1'b0;
            ink           = 16'hFFFF;
            mismatches    = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                CFG_WIN_X_MIN: win_x_min = int'(value[7:0]);
                CFG_WIN_X_MAX: win_x_max = int'(value[7:0]);
                CFG_WIN_Y_MIN: win_y_min = int'(value[7:0]);
                CFG_WIN_Y_MAX: win_y_max = int'(value[7:0]);
                CFG_TERMINAL:  fixed_advance = value[0];
                CFG_WRAP:      wrap_on = value[0];
                CFG_INK:       ink = value;
                default: ;
            endcase
        endfunction

        // Works out the pixel writes of one accepted transaction and moves the cursor.
        function void render_item(gtr_in_t item);
            gtr_out_t    batch[$];
            gtr_out_t    pix;
            logic [7:0]  bits;
            logic [15:0] xw;
            logic [15:0] yw;
            int          adv;
            int          px;
            int          py;
            if (item.op == OP_START) begin
                cursor_col = item.start_x;
                margin_col = item.start_x;
                cursor_row = item.start_y;
            end else if (item.char_code == CHAR_CR) begin
                cursor_col = margin_col;
            end else if (item.char_code == CHAR_LF) begin
                cursor_row = cursor_row + LINE_STEP;
            end else begin
                adv = 0;
                if (item.char_code >= FONT_FIRST && item.char_code <= FONT_LAST) begin
                    adv = GLYPH_W;
                    // Scanning down leaves the lowest blank column in charge of the width.
                    if (!fixed_advance) begin
                        for (int c = GLYPH_W - 1; c >= 1; c--) begin
                            if (glyph_column(item.char_code, c) == 8'h00) begin
                                adv = c + 1;
                            end
                        end
                    end
                    for (int col = 0; col < adv; col++) begin
                        bits = glyph_column(item.char_code, col);
                        xw = cursor_col + 16'(col);
                        px = int'($signed(xw));
                        for (int row = 0; row < GLYPH_HEIGHT; row++) begin
                            yw = cursor_row + 16'(row);
                            py = int'($signed(yw));
                            if (bits[row] && px >= 0 && py >= 0 && py < int'(DISPLAY_HEIGHT)
                                && px >= win_x_min && px < win_x_max
                                && py >= win_y_min && py < win_y_max) begin
                                pix.pixel_x     = xw[7:0];
                                pix.pixel_y     = yw[7:0];
                                pix.pixel_color = ink;
                                pix.last_pixel  = 1'b0;
                                batch.push_back(pix);
                            end
                        end
                    end
                end
                if (batch.size() > 0) begin
                    pix = batch.pop_back();
                    pix.last_pixel = 1'b1;
                    batch.push_back(pix);
                end
                foreach (batch[i]) begin
                    expected_pixels.push_back(batch[i]);
                end
                cursor_col = cursor_col + 16'(adv);
                if (wrap_on && int'($signed(cursor_col)) + GLYPH_W > win_x_max) begin
                    cursor_row = cursor_row + LINE_STEP;
                    cursor_col = margin_col;
                end
            end
        endfunction

        task check_pixel(gtr_out_t got);
            gtr_out_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) arrived with none expected",
                                 got.pixel_x, got.pixel_y));
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_x !== want.pixel_x) begin
                    report($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
                end
                if (got.pixel_y !== want.pixel_y) begin
                    report($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
                end
                if (got.pixel_color !== want.pixel_color) begin
                    report($sformatf("pixel_color %04h, expected %04h",
                                     got.pixel_color, want.pixel_color));
                end
                if (got.last_pixel !== want.last_pixel) begin
                    report($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                     got.last_pixel, want.last_pixel,
                                     want.pixel_x, want.pixel_y));
                end
            end
        endtask
    endclass

endpackage

>>> sim/tb.sv
// Testbench top: drives text transactions and register writes into the rasterizer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtr_pkg::*;
    import pixel_check_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    gtr_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    gtr_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    pixel_scoreboard sb;

    glyph_text_rasterizer_core #(
        .GLYPH_WIDTH(GLYPH_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel(m_data);
        end
    end

    function automatic gtr_in_t make_item(logic op, logic [7:0] code,
                                          logic [15:0] x, logic [15:0] y);
        gtr_in_t item;
        item.op        = op;
        item.char_code = code;
        item.start_x   = x;
        item.start_y   = y;
        return item;
    endfunction

    task automatic send_item(gtr_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.render_item(item);
    endtask

    // cfg_valid is left high so back-to-back writes follow without a gap.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        sb.write_reg(idx, value);
    endtask

    // Waits for every expected pixel, then for the block to finish any silent transaction.
    task automatic drain();
        int waited = 0;
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_pixels.size() != 0) begin
            sb.report($sformatf("%0d expected pixels never arrived",
                                sb.expected_pixels.size()));
            sb.expected_pixels.delete();
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        gtr_in_t     item;
        int          sel;
        int          count;
        int          x_lo;
        int          x_hi;
        int          y_lo;
        int          y_hi;
        logic        term_v;
        logic        wrap_v;
        logic [15:0] ink_v;

        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 15;
        recv_idle_pct = 73;

        // Directed part under the reset register values.
        send_item(make_item(OP_START, 8'hFF, 16'd0, 16'd0));
        send_item(make_item(OP_CHAR, 8'd32, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_CHAR, 8'd33, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd77, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd126, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, FONT_LAST, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, CHAR_CR, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, CHAR_LF, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd0, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd31, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd128, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd255, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, 8'd103, 16'h0000, 16'h0000));
        // Glyph partly above and left of the display.
        send_item(make_item(OP_START, 8'h00, 16'hFFFD, 16'hFFFE));
        send_item(make_item(OP_CHAR, 8'd66, 16'h0000, 16'h0000));
        // Glyph across the right window edge and the bottom of the display.
        send_item(make_item(OP_START, 8'h41, 16'd236, 16'd236));
        send_item(make_item(OP_CHAR, 8'd87, 16'h0000, 16'h0000));
        // Cursor arithmetic that wraps past the top of the signed and unsigned 16-bit ranges.
        send_item(make_item(OP_START, 8'h0D, 16'h7FFF, 16'h7FFD));
        send_item(make_item(OP_CHAR, 8'd72, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, CHAR_LF, 16'h0000, 16'h0000));
        send_item(make_item(OP_START, 8'h0A, 16'h8000, 16'hFFFF));
        send_item(make_item(OP_CHAR, 8'd64, 16'h0000, 16'h0000));
        send_item(make_item(OP_START, 8'h20, 16'd120, 16'd100));
        send_item(make_item(OP_CHAR, 8'd65, 16'h0000, 16'h0000));
        send_item(make_item(OP_CHAR, CHAR_CR, 16'h0000, 16'h0000));

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            if (phase == 2) begin
                send_idle_pct = 73;
                recv_idle_pct = 15;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            x_lo   = 0;
            x_hi   = 240;
            y_lo   = 0;
            y_hi   = 240;
            term_v = 1'b0;
            wrap_v = 1'b1;
            ink_v  = 16'($urandom);
            case (phase)
                0: begin
                    x_hi  = 255;
                    y_hi  = 255;
                    ink_v = 16'h0000;
                end
                1: begin
                    x_lo   = 8;
                    x_hi   = 120;
                    y_lo   = 4;
                    y_hi   = 64;
                    term_v = 1'b1;
                    wrap_v = 1'b0;
                end
                2: begin
                    x_lo   = 40;
                    x_hi   = 200;
                    y_lo   = 16;
                    y_hi   = 120;
                    term_v = 1'b1;
                    ink_v  = 16'hFFFF;
                end
                3: begin
                    // Empty window: nothing is drawn; wrap fires if cursor x + GLYPH_W > 0.
                    x_lo = 255;
                    x_hi = 0;
                    y_lo = 255;
                    y_hi = 0;
                end
                4: begin
                    x_lo   = $urandom_range(0, 120);
                    x_hi   = $urandom_range(100, 255);
                    y_lo   = $urandom_range(0, 100);
                    y_hi   = $urandom_range(60, 255);
                    term_v = 1'($urandom_range(0, 1));
                    wrap_v = 1'($urandom_range(0, 1));
                end
                default: ;
            endcase
            write_cfg(CFG_WIN_X_MIN, {8'($urandom), 8'(x_lo)});
            write_cfg(CFG_WIN_X_MAX, {8'($urandom), 8'(x_hi)});
            write_cfg(CFG_WIN_Y_MIN, {8'($urandom), 8'(y_lo)});
            write_cfg(CFG_WIN_Y_MAX, {8'($urandom), 8'(y_hi)});
            write_cfg(CFG_TERMINAL, {15'($urandom), term_v});
            write_cfg(CFG_WRAP, {15'($urandom), wrap_v});
            write_cfg(CFG_INK, ink_v);
            if (phase == 4) begin
                write_cfg(CFG_UNUSED, 16'($urandom));
            end
            cfg_valid <= 1'b0;

            count = (phase == 3) ? 24 : 90;
            send_item(make_item(OP_START, 8'($urandom),
                                16'(int'($urandom_range(0, 40)) - 4),
                                16'(int'($urandom_range(0, 60)) - 4)));
            for (int i = 0; i < count; i++) begin
                sel  = $urandom_range(0, 99);
                item = make_item(OP_CHAR, 8'($urandom_range(FONT_FIRST, FONT_LAST)),
                                 16'($urandom), 16'($urandom));
                if (sel < 6) begin
                    // A new string, mostly placed on the display, now and then anywhere.
                    item.op        = OP_START;
                    item.char_code = 8'($urandom);
                    if (sel > 0) begin
                        item.start_x = 16'(int'($urandom_range(0, 270)) - 12);
                        item.start_y = 16'(int'($urandom_range(0, 260)) - 12);
                    end
                end else if (sel < 12) begin
                    item.char_code = CHAR_CR;
                end else if (sel < 18) begin
                    item.char_code = CHAR_LF;
                end else if (sel < 22) begin
                    item.char_code = ($urandom_range(0, 1) != 0) ?
                                     8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
                end
                send_item(item);
            end
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
